FILE: hw/rtl/pee_pkg.sv
package pee_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	localparam int DATA_W = 32;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	// character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// operator codes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_OVERFLOW  = 3'd2;
	localparam logic [2:0] ST_DIVZERO   = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	typedef struct packed {
		logic              push_en;
		logic [DATA_W-1:0] push_val;
		logic              op_en;
		logic [1:0]        op;
		logic              last;
	} cmd_t;

endpackage

FILE: hw/rtl/pee_ram.sv
module pee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/pee_div.sv
module pee_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	localparam logic [4:0] LAST_STEP = 5'd31;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  step_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] mb_q;
	logic        neg_q;
	logic [32:0] trial;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[31]} - {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			mb_q  <= divisor[31] ? (32'd0 - divisor) : divisor;
			rem_q <= '0;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
			end
			quo_q <= {quo_q[30:0], ~trial[32]};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

FILE: hw/rtl/pee_front.sv
module pee_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    char_in,
	input  logic          last,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output pee_pkg::cmd_t cmd
);

	import pee_pkg::*;

	logic [DATA_W-1:0] acc_q;
	logic              in_num_q;
	logic [DATA_W-1:0] acc_next;
	logic [DATA_W-1:0] acc_upd;
	logic              in_num_upd;
	logic              is_digit;
	logic              accept;

	always_comb begin
		is_digit = char_in inside {[CH_ZERO:CH_NINE]};
		// acc * 10 + digit, wrapping
		acc_next = (acc_q << 3) + (acc_q << 1) + {28'd0, char_in[3:0]};

		cmd          = '0;
		cmd.last     = last;
		cmd.push_val = acc_q;
		acc_upd      = '0;
		in_num_upd   = 1'b0;

		if (is_digit) begin
			acc_upd      = acc_next;
			in_num_upd   = 1'b1;
			cmd.push_en  = last;
			cmd.push_val = acc_next;
		end else begin
			cmd.push_en = in_num_q;
			case (char_in)
				CH_PLUS: begin
					cmd.op_en = 1'b1;
					cmd.op    = OP_ADD;
				end
				CH_MINUS: begin
					cmd.op_en = 1'b1;
					cmd.op    = OP_SUB;
				end
				CH_STAR: begin
					cmd.op_en = 1'b1;
					cmd.op    = OP_MUL;
				end
				CH_SLASH: begin
					cmd.op_en = 1'b1;
					cmd.op    = OP_DIV;
				end
				CH_SPACE: begin
					cmd.op_en = 1'b0;
				end
				default: begin
					cmd.op_en = 1'b0;
				end
			endcase
		end

		if (last) begin
			acc_upd    = '0;
			in_num_upd = 1'b0;
		end
	end

	// a pure digit mid-number leaves nothing for the back end
	assign in_ready  = cmd_ready;
	assign accept    = in_valid && in_ready;
	assign cmd_valid = accept && (cmd.push_en || cmd.op_en || cmd.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			in_num_q <= 1'b0;
		end else if (accept) begin
			acc_q    <= acc_upd;
			in_num_q <= in_num_upd;
		end
	end

endmodule

FILE: hw/rtl/pee_fifo.sv
module pee_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  pee_pkg::cmd_t wr_cmd,
	output logic          not_full,
	input  logic          rd_en,
	output logic          rd_valid,
	output pee_pkg::cmd_t rd_cmd
);

	import pee_pkg::*;

	cmd_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;
	logic                   do_wr;
	logic                   do_rd;

	assign not_full = cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && not_full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

FILE: hw/rtl/pee_back.sv
module pee_back #(
	parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  pee_pkg::cmd_t             cmd,
	output logic                      cmd_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [pee_pkg::DATA_W-1:0] out_value,
	output logic [2:0]                out_status
);

	import pee_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PUSH  = 3'd1;
	localparam logic [2:0] S_OPCHK = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_END   = 3'd5;

	logic [2:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [2:0]        err_q;
	logic              out_valid_q;
	cmd_t              cmd_q;
	logic [DATA_W-1:0] tos_q;
	logic [DATA_W-1:0] out_value_q;
	logic [2:0]        out_status_q;

	logic [CW-1:0]     count_m1;
	logic [CW-1:0]     count_m2;
	logic              full;
	logic              ram_wr;
	logic              ram_rd;
	logic [DATA_W-1:0] nos;
	logic [DATA_W-1:0] alu_res;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;
	logic              emit;

	// top of stack lives in tos_q, entries below it in the RAM
	assign count_m1 = count_q - CW'(1);
	assign count_m2 = count_q - CW'(2);
	assign full     = count_q == CW'(STACK_DEPTH);
	assign ram_wr   = (state_q == S_PUSH) && cmd_q.push_en && !full && (count_q != '0);
	assign ram_rd   = (state_q == S_OPCHK) && cmd_q.op_en && (count_q >= CW'(2));
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign div_start = (state_q == S_RD) && (cmd_q.op == OP_DIV) && (tos_q != '0);
	assign emit     = (state_q == S_END) && cmd_q.last && (!out_valid_q || out_ready);

	pee_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (count_m1[IW-1:0]),
		.wr_data (tos_q),
		.rd_en   (ram_rd),
		.rd_addr (count_m2[IW-1:0]),
		.rd_data (nos)
	);

	pee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nos),
		.divisor  (tos_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		case (cmd_q.op)
			OP_ADD:  alu_res = nos + tos_q;
			OP_SUB:  alu_res = nos - tos_q;
			OP_MUL:  alu_res = nos * tos_q;
			default: alu_res = nos + tos_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (cmd_q.push_en) begin
						if (full) begin
							err_q <= (err_q == ST_OK) ? ST_OVERFLOW : err_q;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
					state_q <= S_OPCHK;
				end
				S_OPCHK: begin
					if (!cmd_q.op_en) begin
						state_q <= S_END;
					end else if (count_q < CW'(2)) begin
						err_q   <= (err_q == ST_OK) ? ST_UNDERFLOW : err_q;
						state_q <= S_END;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (cmd_q.op != OP_DIV) begin
						count_q <= count_m1;
						state_q <= S_END;
					end else if (tos_q == '0) begin
						err_q   <= (err_q == ST_OK) ? ST_DIVZERO : err_q;
						state_q <= S_END;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						count_q <= count_m1;
						state_q <= S_END;
					end
				end
				S_END: begin
					if (!cmd_q.last) begin
						state_q <= S_IDLE;
					end else if (emit) begin
						out_valid_q <= 1'b1;
						count_q     <= '0;
						err_q       <= ST_OK;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if ((state_q == S_PUSH) && cmd_q.push_en && !full) begin
			tos_q <= cmd_q.push_val;
		end else if ((state_q == S_RD) && (cmd_q.op != OP_DIV)) begin
			tos_q <= alu_res;
		end else if ((state_q == S_DIV) && div_done) begin
			tos_q <= div_quo;
		end
		if (emit) begin
			out_value_q <= (count_q == '0) ? '0 : tos_q;
			if (err_q != ST_OK) begin
				out_status_q <= err_q;
			end else if (count_q == '0) begin
				out_status_q <= ST_EMPTY;
			end else begin
				out_status_q <= ST_OK;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;

endmodule

FILE: hw/rtl/postfix_expression_evaluator_unit.sv
// Postfix (RPN) evaluator over an ASCII byte stream. The front end takes one
// byte per cycle while the queue has room, builds decimal numbers and passes
// push/operator commands through a 4-entry queue; digits inside a number
// leave no command. The back end runs a plain command (a push, a byte ending
// a number, a bare last byte) through the states idle, push, operand check
// and end; + - * add a state reading the second operand from the stack RAM,
// and / also waits on the 32-step restoring divider. A byte marked tlast
// yields one item of value and status; the stack holds STACK_DEPTH operands
// and is empty again after each result. Status: 0 ok, 1 underflow, 2 overflow,
// 3 divide by zero, 4 empty stack; only an expression's first error is kept.
module postfix_expression_evaluator_unit #(
	parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // [31:0] value, [34:32] status, rest zero
);

	import pee_pkg::*;

	cmd_t              fe_cmd;
	logic              fe_cmd_valid;
	logic              q_not_full;
	logic              q_valid;
	cmd_t              q_cmd;
	logic              q_pop;
	logic [DATA_W-1:0] res_value;
	logic [2:0]        res_status;

	pee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.char_in   (s_axis_tdata),
		.last      (s_axis_tlast),
		.cmd_valid (fe_cmd_valid),
		.cmd_ready (q_not_full),
		.cmd       (fe_cmd)
	);

	pee_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fe_cmd_valid),
		.wr_cmd   (fe_cmd),
		.not_full (q_not_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_cmd   (q_cmd)
	);

	pee_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd        (q_cmd),
		.cmd_pop    (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (res_value),
		.out_status (res_status)
	);

	assign m_axis_tdata = {5'd0, res_status, res_value};

endmodule

FILE: hw/rtl/pee_checker.sv
module pee_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	import pee_pkg::*;

	// a result waiting for the sink must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[34:32] == ST_OK || m_axis_tdata[34:32] == ST_UNDERFLOW
			|| m_axis_tdata[34:32] == ST_OVERFLOW || m_axis_tdata[34:32] == ST_DIVZERO
			|| m_axis_tdata[34:32] == ST_EMPTY)
		else $error("status code out of range");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[34:32] == ST_EMPTY |-> m_axis_tdata[31:0] == 32'd0)
		else $error("empty stack result with nonzero value");

	// bits above status stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
		else $error("result item padding not zero");

	// out of reset: input open, no result pending
	a_ready_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> s_axis_tready && !m_axis_tvalid)
		else $error("block not ready after reset");

endmodule

bind postfix_expression_evaluator_unit pee_checker u_pee_checker (.*);
